[src/fqd_pkg.sv]
// Package: shared types and codes for the FIFO queue with delete.
`timescale 1ns / 1ps

package fqd_pkg;

   localparam int HANDLE_W = 32;
   localparam int COUNT_W  = 5;

   localparam logic [1:0] MODE_ENQ = 2'd0;
   localparam logic [1:0] MODE_DEQ = 2'd1;
   localparam logic [1:0] MODE_DEL = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [1:0]          mode;
      logic [HANDLE_W-1:0] handle_in;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [HANDLE_W-1:0] handle_out;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } done_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DEQ_WAIT,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage

[src/fqd_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module fqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/fqd_ctrl.sv]
// Sequencer: circular buffer pointers, delete scan and compaction over the slot RAM.
`timescale 1ns / 1ps

module fqd_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  fqd_pkg::req_type req_payload,
   input  logic            rsp_free,
   output fqd_pkg::done_type done
);

   import fqd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   state_type state_ff, state_in;

   logic [1:0]          mode_ff,   mode_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [AW-1:0]       head_ff,   head_in;
   logic [CW-1:0]       count_ff,  count_in;
   logic [CW-1:0]       idx_ff,    idx_in;
   logic [CW-1:0]       widx_ff,   widx_in;
   logic                pend_ff,   pend_in;
   logic                status_ff, status_in;
   logic [HANDLE_W-1:0] hout_ff,   hout_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [HANDLE_W-1:0] ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [HANDLE_W-1:0] ram_rdata;

   logic                accept;
   logic                enq_ok, deq_ok, del_go;
   logic                scan_hit, idx_more;
   logic [CW+4:0]       count_ext;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] idx);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(idx);
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[AW-1:0];
   endfunction

   fqd_ram #(
      .WIDTH(HANDLE_W),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign enq_ok    = (handle_ff != '0) && (count_ff < DEPTH_C);
   assign deq_ok    = (count_ff != '0);
   assign del_go    = (handle_ff != '0) && (count_ff != '0);
   assign scan_hit  = pend_ff && (ram_rdata == handle_ff);
   assign idx_more  = (idx_ff < count_ff);
   assign count_ext = (CW + 5)'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (mode_ff)
               MODE_DEQ: state_in = deq_ok ? ST_DEQ_WAIT : ST_DONE;
               MODE_DEL: state_in = del_go ? ST_SCAN : ST_DONE;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_DEQ_WAIT: state_in = ST_DONE;
         ST_SCAN: begin
            if (scan_hit) state_in = ST_SHIFT;
            else if (!idx_more) state_in = ST_DONE;
         end
         ST_SHIFT: begin
            if (!idx_more && !pend_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM controls
   always_comb begin
      mode_in   = mode_ff;
      handle_in = handle_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      widx_in   = widx_ff;
      pend_in   = pend_ff;
      status_in = status_ff;
      hout_in   = hout_ff;
      ram_we    = 1'b0;
      ram_waddr = phys(head_ff, widx_ff);
      ram_wdata = ram_rdata;
      ram_raddr = phys(head_ff, idx_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = req_payload.mode;
               handle_in = req_payload.handle_in;
            end
         end
         ST_DISPATCH: begin
            status_in = STATUS_ERR;
            hout_in   = '0;
            idx_in    = '0;
            pend_in   = 1'b0;
            unique case (mode_ff)
               MODE_ENQ: begin
                  if (enq_ok) begin
                     ram_we    = 1'b1;
                     ram_waddr = phys(head_ff, count_ff);
                     ram_wdata = handle_ff;
                     count_in  = count_ff + CW'(1);
                     status_in = STATUS_OK;
                  end
               end
               MODE_DEQ: ram_raddr = head_ff;
               default: ;
            endcase
         end
         ST_DEQ_WAIT: begin
            hout_in   = ram_rdata;
            head_in   = (head_ff == LAST_A) ? '0 : head_ff + AW'(1);
            count_in  = count_ff - CW'(1);
            status_in = STATUS_OK;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               // matched entry sits at idx - 1; younger entries start at idx
               widx_in = idx_ff - CW'(1);
               pend_in = 1'b0;
            end else if (idx_more) begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               ram_we  = 1'b1;
               widx_in = widx_ff + CW'(1);
            end
            if (idx_more) begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in  = count_ff - CW'(1);
                  status_in = STATUS_OK;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      done.valid          = (state_ff == ST_DONE);
      done.rsp.status     = status_ff;
      done.rsp.handle_out = hout_ff;
      done.rsp.count      = count_ext[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      handle_ff <= handle_in;
      idx_ff    <= idx_in;
      widx_ff   <= widx_in;
      status_ff <= status_in;
      hout_ff   <= hout_in;
   end

endmodule

[src/fifo_queue_with_delete.sv]
// Top level: FIFO queue of handles with delete by value, registered response.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------
//   req     | in  | req_valid/req_stall  | req_payload (mode, handle_in)
//   rsp     | out | rsp_valid/rsp_stall  | rsp_payload (status, handle_out, count)
//
// One transaction at a time, set by the sequencer walking the slot RAM one port per cycle.
// Enqueue, and errors found at dispatch, go through dispatch and done; dequeue adds a read wait.
// Delete scans the entries from the head for a match, then shifts the younger entries down
// over it; when the handle is absent the scan runs to the tail and ends in an error.
// Reset clears occupancy and pointers; the slot RAM is not cleared.
// A stalled response holds; the next transaction is taken while it waits.
`timescale 1ns / 1ps

module fifo_queue_with_delete #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fqd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fqd_pkg::rsp_type rsp_payload
);

   import fqd_pkg::*;

   done_type done;
   logic     rsp_free;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff,       rsp_in;

   fqd_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_free    (rsp_free),
      .done        (done)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_free) begin
         rsp_valid_in = done.valid;
         if (done.valid) rsp_in = done.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_err_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_ERR |-> rsp_payload.handle_out == '0)
      else $error("error response carries a handle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a transaction is in progress");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      done.valid && !rsp_free |=> done.valid && $stable(done.rsp))
      else $error("finished transaction lost while response stalled");
`endif

endmodule
